/* rtl/core/afcr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package afcr_pkg;

	localparam int NUM_W      = 32;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = NUM_W / DIV_STEPS;

	typedef struct packed {
		logic               has_image;
		logic [13:0]        image_width;
		logic [13:0]        image_height;
		logic signed [15:0] area_min_x;
		logic signed [15:0] area_min_y;
		logic signed [15:0] area_max_x;
		logic signed [15:0] area_max_y;
	} req_t;

	typedef struct packed {
		logic signed [15:0] place_min_x;
		logic signed [15:0] place_min_y;
		logic signed [15:0] place_max_x;
		logic signed [15:0] place_max_y;
	} rsp_t;

	// per-beat context carried alongside the dividers
	typedef struct packed {
		logic        native;
		logic [13:0] w;
		logic [13:0] h;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
		logic [15:0] mw;
		logic [15:0] mh;
	} ctx_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [14:0]      rem;
		logic [NUM_W-1:0] quo;
	} div_t;

endpackage

`default_nettype wire

/* rtl/core/aspect_fit_center_rect_unit.sv */
// a beat is registered in the input, numerator, divider, axis, size and edge stages before done rises
// throughput: one beat per cycle; busy is never raised and done cannot be stalled
// the two 32-bit quotients come from 8 divider stages of 4 restoring steps each
// reset clears only the valid bits of the pipeline; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module aspect_fit_center_rect_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire afcr_pkg::req_t item,
	output logic               done,
	output afcr_pkg::rsp_t     result
);

	function automatic afcr_pkg::div_t div_step(afcr_pkg::div_t a, logic [14:0] d);
		afcr_pkg::div_t r;
		logic [15:0]    t;
		r = a;
		for (int i = 0; i < afcr_pkg::DIV_STEPS; i++) begin
			t = {r.rem, r.num[afcr_pkg::NUM_W-1]};
			r.num = {r.num[afcr_pkg::NUM_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				r.rem = 15'(t - {1'b0, d});
				r.quo = {r.quo[afcr_pkg::NUM_W-2:0], 1'b1};
			end else begin
				r.rem = t[14:0];
				r.quo = {r.quo[afcr_pkg::NUM_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	assign busy = 1'b0;

	// input stage: extents clamped at zero
	logic               vld_in;
	logic signed [16:0] ext_x;
	logic signed [16:0] ext_y;
	afcr_pkg::ctx_t     ctx_in;

	always_comb begin
		vld_in = start && item.has_image && (item.image_width != 14'd0)
			&& (item.image_height != 14'd0);
		ext_x = {item.area_max_x[15], item.area_max_x} - {item.area_min_x[15], item.area_min_x};
		ext_y = {item.area_max_y[15], item.area_max_y} - {item.area_min_y[15], item.area_min_y};
		ctx_in.native = 1'b0;
		ctx_in.w  = item.image_width;
		ctx_in.h  = item.image_height;
		ctx_in.x0 = item.area_min_x;
		ctx_in.y0 = item.area_min_y;
		ctx_in.x1 = item.area_max_x;
		ctx_in.y1 = item.area_max_y;
		ctx_in.mw = ext_x[16] ? 16'd0 : ext_x[15:0];
		ctx_in.mh = ext_y[16] ? 16'd0 : ext_y[15:0];
	end

	logic           vld_s1;
	afcr_pkg::ctx_t ctx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx_in;
	end

	// products and numerators
	logic [29:0]    prod_w;
	logic [29:0]    prod_h;
	afcr_pkg::ctx_t ctx_nx;

	always_comb begin
		prod_w = 30'(ctx_s1.mh) * 30'(ctx_s1.w);
		prod_h = 30'(ctx_s1.mw) * 30'(ctx_s1.h);
		ctx_nx = ctx_s1;
		ctx_nx.native = ({2'b0, ctx_s1.w} < ctx_s1.mw) && ({2'b0, ctx_s1.h} < ctx_s1.mh);
	end

	logic           vld_s2;
	afcr_pkg::ctx_t ctx_s2;
	afcr_pkg::div_t dsw_s2;
	afcr_pkg::div_t dsh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s2     <= ctx_nx;
		dsw_s2.num <= {1'b0, prod_w, 1'b0} + 32'(ctx_s1.h);
		dsw_s2.rem <= '0;
		dsw_s2.quo <= '0;
		dsh_s2.num <= {1'b0, prod_h, 1'b0} + 32'(ctx_s1.w);
		dsh_s2.rem <= '0;
		dsh_s2.quo <= '0;
	end

	// divider pipeline
	logic           dv_s  [afcr_pkg::DIV_STAGES];
	afcr_pkg::ctx_t dc_s  [afcr_pkg::DIV_STAGES];
	afcr_pkg::div_t dsw_s [afcr_pkg::DIV_STAGES];
	afcr_pkg::div_t dsh_s [afcr_pkg::DIV_STAGES];

	genvar k;
	generate
		for (k = 0; k < afcr_pkg::DIV_STAGES; k++) begin : g_div
			if (k == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						dv_s[k] <= 1'b0;
					end else begin
						dv_s[k] <= vld_s2;
					end
				end
				always_ff @(posedge clk) begin
					dc_s[k]  <= ctx_s2;
					dsw_s[k] <= div_step(dsw_s2, {ctx_s2.h, 1'b0});
					dsh_s[k] <= div_step(dsh_s2, {ctx_s2.w, 1'b0});
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						dv_s[k] <= 1'b0;
					end else begin
						dv_s[k] <= dv_s[k-1];
					end
				end
				always_ff @(posedge clk) begin
					dc_s[k]  <= dc_s[k-1];
					dsw_s[k] <= div_step(dsw_s[k-1], {dc_s[k-1].h, 1'b0});
					dsh_s[k] <= div_step(dsh_s[k-1], {dc_s[k-1].w, 1'b0});
				end
			end
		end
	endgenerate

	localparam int LAST = afcr_pkg::DIV_STAGES - 1;

	// axis decision
	logic           vld_s11;
	afcr_pkg::ctx_t ctx_s11;
	logic           sw_lt_s11;
	logic [15:0]    sw_s11;
	logic [16:0]    sh_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else begin
			vld_s11 <= dv_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		ctx_s11   <= dc_s[LAST];
		sw_lt_s11 <= dsw_s[LAST].quo < {16'd0, dc_s[LAST].mw};
		sw_s11    <= dsw_s[LAST].quo[15:0];
		sh_s11    <= dsh_s[LAST].quo[16:0];
	end

	// sizes and centering offsets
	logic               apply_x;
	logic               apply_y;
	logic [15:0]        size_x;
	logic [16:0]        size_y;
	logic [16:0]        diff_x;
	logic signed [17:0] diff_y;
	logic [16:0]        half_x;
	logic signed [17:0] half_y;

	always_comb begin
		apply_x = ctx_s11.native || sw_lt_s11;
		apply_y = ctx_s11.native || !sw_lt_s11;
		size_x  = ctx_s11.native ? {2'b0, ctx_s11.w} : sw_s11;
		size_y  = ctx_s11.native ? {3'b0, ctx_s11.h} : sh_s11;
		diff_x  = {1'b0, ctx_s11.mw} - {1'b0, size_x};
		diff_y  = $signed({2'b0, ctx_s11.mh}) - $signed({1'b0, size_y});
		half_x  = (diff_x + 17'd1) >> 1;
		half_y  = (diff_y + (diff_y[17] ? 18'sd0 : 18'sd1)) >>> 1;
	end

	logic           vld_s12;
	afcr_pkg::ctx_t ctx_s12;
	logic           apx_s12;
	logic           apy_s12;
	logic [15:0]    szx_s12;
	logic [15:0]    szy_s12;
	logic [15:0]    hfx_s12;
	logic [15:0]    hfy_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s12 <= ctx_s11;
		apx_s12 <= apply_x;
		apy_s12 <= apply_y;
		szx_s12 <= size_x;
		szy_s12 <= size_y[15:0];
		hfx_s12 <= half_x[15:0];
		hfy_s12 <= half_y[15:0];
	end

	// edges
	logic [15:0] px0;
	logic [15:0] py0;
	logic [15:0] px1;
	logic [15:0] py1;

	always_comb begin
		px0 = apx_s12 ? ctx_s12.x0 + hfx_s12 : ctx_s12.x0;
		py0 = apy_s12 ? ctx_s12.y0 + hfy_s12 : ctx_s12.y0;
		px1 = apx_s12 ? px0 + szx_s12 : ctx_s12.x1;
		py1 = apy_s12 ? py0 + szy_s12 : ctx_s12.y1;
	end

	logic           vld_s13;
	afcr_pkg::rsp_t rsp_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
		end else begin
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s13.place_min_x <= px0;
		rsp_s13.place_min_y <= py0;
		rsp_s13.place_max_x <= px1;
		rsp_s13.place_max_y <= py1;
	end

	assign done   = vld_s13;
	assign result = rsp_s13;

endmodule

`default_nettype wire
